/* rtl/core/assert_macros.svh */
// Assertion macros shared by the core RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/tspw_pkg.sv */
// Shared types, widths and angle tables for the three-step phase wrap core.
// Tables are built at elaboration from pi in Q4.60 by Taylor series.
// No dependencies.
package tspw_pkg;

   localparam int FRAC_BITS   = 60;
   localparam int ANGLE_STEPS = 64;
   localparam logic [63:0] PI_Q60 = 64'd3622009729038561421;

   // datapath widths
   localparam int ASQ_W    = 16;  // a*a, a <= 255
   localparam int BSQ_W    = 18;  // b*b, b <= 510
   localparam int ENERGY_W = 19;  // 3a^2 + b^2
   localparam int RAD_W    = 16;
   localparam int ROOT_W   = 8;
   localparam int STEP_W   = 6;   // angle step index 0..63
   localparam int C3_W     = 62;  // 3cos^2 in Q4.60 is below 2^62
   localparam int SN_W     = 61;  // sin^2 in Q4.60 is at most 2^60
   localparam int SPLIT    = 31;  // constant split point for partial products
   localparam int PROD_W   = 80;
   localparam int THR_W    = 9;

   localparam logic [THR_W-1:0] THRESH_RESET = 9'd64;

   // phase codes on the axes
   localparam logic [7:0] CODE_ZERO     = 8'h00;
   localparam logic [7:0] CODE_PI       = 8'h80;
   localparam logic [7:0] CODE_HALF_PI  = 8'h40;
   localparam logic [7:0] CODE_NHALF_PI = 8'hC0;
   localparam logic [6:0] MAG_PI        = 7'd127;
   localparam logic [ROOT_W-1:0] MOD_SAT = 8'hFF;

   typedef logic [ANGLE_STEPS-1:0][63:0] angle_table_type;

   typedef struct packed {
      logic v_neg;
      logic u_neg;
      logic v_zero;
      logic u_zero;
   } flags_type;

   // payload handed between square-root cells
   typedef struct packed {
      logic [ASQ_W-1:0]  a_sq;
      logic [BSQ_W-1:0]  b_sq;
      flags_type         flags;
      logic [RAD_W-1:0]  rad;
      logic              sat;
      logic [ROOT_W-1:0] root;
   } sqrt_stage_type;

   // payload handed between phase cells
   typedef struct packed {
      logic [ASQ_W-1:0]  a_sq;
      logic [BSQ_W-1:0]  b_sq;
      flags_type         flags;
      logic [ROOT_W-1:0] modv;
      logic [STEP_W-1:0] m;
   } phase_stage_type;

   // Q4.60 product, truncated
   function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'b0, a} * {64'b0, b};
      return p[FRAC_BITS+63:FRAC_BITS];
   endfunction

   function automatic logic [63:0] sin_series(input logic [63:0] x);
      logic [63:0] x2, t, pos, neg;
      x2  = mul_q(x, x);
      t   = x;
      pos = x;
      neg = 64'd0;
      t = mul_q(t, x2) / 64'd6;   neg = neg + t;
      t = mul_q(t, x2) / 64'd20;  pos = pos + t;
      t = mul_q(t, x2) / 64'd42;  neg = neg + t;
      t = mul_q(t, x2) / 64'd72;  pos = pos + t;
      t = mul_q(t, x2) / 64'd110; neg = neg + t;
      t = mul_q(t, x2) / 64'd156; pos = pos + t;
      t = mul_q(t, x2) / 64'd210; neg = neg + t;
      t = mul_q(t, x2) / 64'd272; pos = pos + t;
      t = mul_q(t, x2) / 64'd342; neg = neg + t;
      t = mul_q(t, x2) / 64'd420; pos = pos + t;
      t = mul_q(t, x2) / 64'd506; neg = neg + t;
      t = mul_q(t, x2) / 64'd600; pos = pos + t;
      t = mul_q(t, x2) / 64'd702; neg = neg + t;
      t = mul_q(t, x2) / 64'd812; pos = pos + t;
      t = mul_q(t, x2) / 64'd930; neg = neg + t;
      return pos - neg;
   endfunction

   function automatic logic [63:0] cos_series(input logic [63:0] x);
      logic [63:0] x2, t, pos, neg;
      x2  = mul_q(x, x);
      t   = 64'd1 << FRAC_BITS;
      pos = t;
      neg = 64'd0;
      t = mul_q(t, x2) / 64'd2;   neg = neg + t;
      t = mul_q(t, x2) / 64'd12;  pos = pos + t;
      t = mul_q(t, x2) / 64'd30;  neg = neg + t;
      t = mul_q(t, x2) / 64'd56;  pos = pos + t;
      t = mul_q(t, x2) / 64'd90;  neg = neg + t;
      t = mul_q(t, x2) / 64'd132; pos = pos + t;
      t = mul_q(t, x2) / 64'd182; neg = neg + t;
      t = mul_q(t, x2) / 64'd240; pos = pos + t;
      t = mul_q(t, x2) / 64'd306; neg = neg + t;
      t = mul_q(t, x2) / 64'd380; pos = pos + t;
      t = mul_q(t, x2) / 64'd462; neg = neg + t;
      t = mul_q(t, x2) / 64'd552; pos = pos + t;
      t = mul_q(t, x2) / 64'd650; neg = neg + t;
      t = mul_q(t, x2) / 64'd756; pos = pos + t;
      t = mul_q(t, x2) / 64'd870; neg = neg + t;
      t = mul_q(t, x2) / 64'd992; pos = pos + t;
      return pos - neg;
   endfunction

   // 3*cos^2(k*pi/128), entry 0 unused
   function automatic angle_table_type build_cos3();
      angle_table_type tab;
      logic [63:0]     x, c;
      tab = '0;
      for (int k = 1; k < ANGLE_STEPS; k++) begin
         x = (PI_Q60 >> 7) * 64'(k);
         c = cos_series(x);
         tab[k[STEP_W-1:0]] = 64'd3 * mul_q(c, c);
      end
      return tab;
   endfunction

   // sin^2(k*pi/128), entry 0 unused
   function automatic angle_table_type build_sin();
      angle_table_type tab;
      logic [63:0]     x, s;
      tab = '0;
      for (int k = 1; k < ANGLE_STEPS; k++) begin
         x = (PI_Q60 >> 7) * 64'(k);
         s = sin_series(x);
         tab[k[STEP_W-1:0]] = mul_q(s, s);
      end
      return tab;
   endfunction

   localparam angle_table_type COS3_SQ = build_cos3();
   localparam angle_table_type SIN_SQ  = build_sin();

endpackage

/* rtl/core/tspw_sqrt_cell.sv */
// One cell of the square-root chain: decides one root bit per request.
// Depends on tspw_pkg.
module tspw_sqrt_cell #(
   parameter int BIT = 7
) (
   input  logic                     clock,
   input  logic                     adv,
   input  tspw_pkg::sqrt_stage_type d_in,
   output tspw_pkg::sqrt_stage_type d_out
);

   localparam int RW = tspw_pkg::ROOT_W;
   localparam int QW = tspw_pkg::RAD_W;
   localparam logic [RW-1:0] BIT_MASK = RW'(1) << BIT;

   tspw_pkg::sqrt_stage_type out_ff, out_in;
   logic [RW-1:0] cand;
   logic [QW-1:0] cand_sq;

   // trial bit: keep it when its square still fits under the radicand
   always_comb begin
      cand    = d_in.root | BIT_MASK;
      cand_sq = QW'(cand) * QW'(cand);
      out_in  = d_in;
      if (cand_sq <= d_in.rad) begin
         out_in.root = cand;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign d_out = out_ff;

endmodule

/* rtl/core/tspw_phase_cell.sv */
// One cell of the phase chain: one binary-search step over the angle table.
// Three stages: table select, partial products, combine and compare. Depends on tspw_pkg.
module tspw_phase_cell #(
   parameter int STEP = 32
) (
   input  logic                      clock,
   input  logic [2:0]                adv,
   input  tspw_pkg::phase_stage_type d_in,
   output tspw_pkg::phase_stage_type d_out
);

   localparam int KW   = tspw_pkg::STEP_W;
   localparam int AW   = tspw_pkg::ASQ_W;
   localparam int BW   = tspw_pkg::BSQ_W;
   localparam int CW   = tspw_pkg::C3_W;
   localparam int SW   = tspw_pkg::SN_W;
   localparam int SP   = tspw_pkg::SPLIT;
   localparam int PW   = tspw_pkg::PROD_W;
   localparam int AH_W = AW + CW - SP;
   localparam int AL_W = AW + SP;
   localparam int BH_W = BW + SW - SP;
   localparam int BL_W = BW + SP;

   // stage A: probe index and its table constants
   tspw_pkg::phase_stage_type a_ff;
   logic [KW-1:0] ka_ff, ka_in;
   logic [CW-1:0] c3_ff;
   logic [SW-1:0] sn_ff;

   // stage B: partial products
   tspw_pkg::phase_stage_type b_ff;
   logic [KW-1:0]   kb_ff;
   logic [AH_W-1:0] p_ah_ff, p_ah_in;
   logic [AL_W-1:0] p_al_ff, p_al_in;
   logic [BH_W-1:0] p_bh_ff, p_bh_in;
   logic [BL_W-1:0] p_bl_ff, p_bl_in;

   // stage C: search result
   tspw_pkg::phase_stage_type out_ff, out_in;
   logic [PW-1:0] lhs, rhs;

   assign ka_in = d_in.m + KW'(STEP);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a_ff  <= d_in;
         ka_ff <= ka_in;
         c3_ff <= tspw_pkg::COS3_SQ[ka_in][CW-1:0];
         sn_ff <= tspw_pkg::SIN_SQ[ka_in][SW-1:0];
      end
   end

   // a^2 * 3cos^2 and b^2 * sin^2, each split in two halves
   always_comb begin
      p_ah_in = AH_W'(a_ff.a_sq) * AH_W'(c3_ff[CW-1:SP]);
      p_al_in = AL_W'(a_ff.a_sq) * AL_W'(c3_ff[SP-1:0]);
      p_bh_in = BH_W'(a_ff.b_sq) * BH_W'(sn_ff[SW-1:SP]);
      p_bl_in = BL_W'(a_ff.b_sq) * BL_W'(sn_ff[SP-1:0]);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         b_ff    <= a_ff;
         kb_ff   <= ka_ff;
         p_ah_ff <= p_ah_in;
         p_al_ff <= p_al_in;
         p_bh_ff <= p_bh_in;
         p_bl_ff <= p_bl_in;
      end
   end

   // angle lies above the probe: move the search base up
   always_comb begin
      lhs    = (PW'(p_ah_ff) << SP) + PW'(p_al_ff);
      rhs    = (PW'(p_bh_ff) << SP) + PW'(p_bl_ff);
      out_in = b_ff;
      if (lhs > rhs) begin
         out_in.m = kb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         out_ff <= out_in;
      end
   end

   assign d_out = out_ff;

endmodule

/* rtl/core/three_step_phase_wrap_core.sv */
// Three-step phase wrap core: wrapped phase, modulation and mask per pixel.
// Depends on tspw_pkg, tspw_sqrt_cell, tspw_phase_cell and assert_macros.svh.
//
//   port group | dir | handshake            | payload
//   req_       | in  | req_valid/req_stall  | intensity_one/two/three, 8b each
//   rsp_       | out | rsp_valid/rsp_stall  | phase_code s8, modulation 8b, masked
//   csr_       | in  | csr_write_en         | noise_threshold, 9b
//
// One request per cycle while req_stall is low; the chain is an input stage,
// eight square-root cells, six phase cells of three stages each, output register.
// Each stage has its own valid bit, so bubbles close up behind a stalled output;
// req_stall rises only when every stage is full and rsp_stall is high.
// Reset clears the stage valid bits and loads noise_threshold with 64.
`include "assert_macros.svh"

module three_step_phase_wrap_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_intensity_one,
   input  logic [7:0]        req_intensity_two,
   input  logic [7:0]        req_intensity_three,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [7:0] rsp_phase_code,
   output logic [7:0]        rsp_modulation,
   output logic              rsp_masked,
   input  logic              csr_write_en,
   input  logic [8:0]        csr_write_data
);

   localparam int N_SQRT  = tspw_pkg::ROOT_W;
   localparam int N_PHASE = tspw_pkg::STEP_W;
   localparam int FIRST_PH = 1 + N_SQRT;
   localparam int N_STAGE = 2 + N_SQRT + 3 * N_PHASE;
   localparam int LAST    = N_STAGE - 1;
   localparam int EW      = tspw_pkg::ENERGY_W;
   localparam int AW      = tspw_pkg::ASQ_W;
   localparam int BW      = tspw_pkg::BSQ_W;

   logic [N_STAGE-1:0] vld_ff, vld_in, adv;
   logic [tspw_pkg::THR_W-1:0] noise_threshold_ff;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         noise_threshold_ff <= tspw_pkg::THRESH_RESET;
      end else if (csr_write_en) begin
         noise_threshold_ff <= csr_write_data;
      end
   end

   // stage s may load unless it and everything after it is full and output stalls
   always_comb begin
      for (int s = 0; s < N_STAGE; s++) begin
         adv[s] = !((&(vld_ff | ((N_STAGE'(1) << s) - N_STAGE'(1)))) && rsp_stall);
      end
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int s = 1; s < N_STAGE; s++) begin
         vld_in[s] = adv[s] ? vld_ff[s-1] : vld_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = vld_ff[LAST];

   // input stage: differences, magnitudes, squares and energy
   logic [8:0]    v_diff;
   logic [9:0]    u_diff;
   logic [7:0]    a_mag;
   logic [8:0]    b_mag;
   logic [AW-1:0] a_sq;
   logic [BW-1:0] b_sq;
   logic [EW-1:0] energy;
   tspw_pkg::sqrt_stage_type s0_ff, s0_in;

   always_comb begin
      v_diff = {1'b0, req_intensity_one} - {1'b0, req_intensity_three};
      u_diff = {1'b0, req_intensity_two, 1'b0} - {2'b0, req_intensity_one}
               - {2'b0, req_intensity_three};
      a_mag  = v_diff[8] ? 8'(-v_diff) : v_diff[7:0];
      b_mag  = u_diff[9] ? 9'(-u_diff) : u_diff[8:0];
      a_sq   = AW'(a_mag) * AW'(a_mag);
      b_sq   = BW'(b_mag) * BW'(b_mag);
      energy = EW'(a_sq) + (EW'(a_sq) << 1) + EW'(b_sq);
      s0_in.a_sq         = a_sq;
      s0_in.b_sq         = b_sq;
      s0_in.flags.v_neg  = v_diff[8];
      s0_in.flags.u_neg  = u_diff[9];
      s0_in.flags.v_zero = (v_diff == 9'd0);
      s0_in.flags.u_zero = (u_diff == 10'd0);
      s0_in.rad          = energy[tspw_pkg::RAD_W-1:0];
      s0_in.sat          = |energy[EW-1:tspw_pkg::RAD_W];
      s0_in.root         = '0;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s0_ff <= s0_in;
      end
   end

   // square-root chain, most significant root bit first
   tspw_pkg::sqrt_stage_type sq_bus [0:N_SQRT];
   assign sq_bus[0] = s0_ff;

   for (genvar i = 0; i < N_SQRT; i++) begin : g_sqrt
      tspw_sqrt_cell #(
         .BIT(N_SQRT - 1 - i)
      ) u_cell (
         .clock(clock),
         .adv  (adv[1 + i]),
         .d_in (sq_bus[i]),
         .d_out(sq_bus[i + 1])
      );
   end

   // phase chain: binary search over the 63 angle steps
   tspw_pkg::phase_stage_type ph_bus [0:N_PHASE];

   always_comb begin
      ph_bus[0].a_sq  = sq_bus[N_SQRT].a_sq;
      ph_bus[0].b_sq  = sq_bus[N_SQRT].b_sq;
      ph_bus[0].flags = sq_bus[N_SQRT].flags;
      ph_bus[0].modv  = sq_bus[N_SQRT].sat ? tspw_pkg::MOD_SAT : sq_bus[N_SQRT].root;
      ph_bus[0].m     = '0;
   end

   for (genvar j = 0; j < N_PHASE; j++) begin : g_phase
      tspw_phase_cell #(
         .STEP((1 << (N_PHASE - 1)) >> j)
      ) u_cell (
         .clock(clock),
         .adv  (adv[FIRST_PH + 3 * j +: 3]),
         .d_in (ph_bus[j]),
         .d_out(ph_bus[j + 1])
      );
   end

   // output stage: fold quadrant, place axis codes, mask
   tspw_pkg::phase_stage_type fin;
   logic [6:0] mag;
   logic [7:0] code_ff, code_in;
   logic [7:0] mod_ff;
   logic       masked_ff, masked_in;

   always_comb begin
      fin = ph_bus[N_PHASE];
      mag = fin.flags.u_neg ? (tspw_pkg::MAG_PI - {1'b0, fin.m}) : {1'b0, fin.m};
      if (fin.flags.v_zero) begin
         code_in = fin.flags.u_neg ? tspw_pkg::CODE_PI : tspw_pkg::CODE_ZERO;
      end else if (fin.flags.u_zero) begin
         code_in = fin.flags.v_neg ? tspw_pkg::CODE_NHALF_PI : tspw_pkg::CODE_HALF_PI;
      end else begin
         code_in = fin.flags.v_neg ? (8'd0 - {1'b0, mag}) : {1'b0, mag};
      end
      masked_in = ({1'b0, fin.modv} < noise_threshold_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[LAST]) begin
         code_ff   <= code_in;
         mod_ff    <= fin.modv;
         masked_ff <= masked_in;
      end
   end

   assign rsp_phase_code = code_ff;
   assign rsp_modulation = mod_ff;
   assign rsp_masked     = masked_ff;

   // checks
   `ASSERT_IMPLIES(a_stall_only_full, clock, reset, req_stall, &vld_ff, "input stalled with a free stage")
   `ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && !req_stall, vld_ff[0], "accepted request lost at input stage")
   `ASSERT_ALWAYS(a_fill_step, clock, reset, $countones(vld_ff) <= $past($countones(vld_ff)) + 1, "pipeline grew by more than one request")
   `ASSERT_IMPLIES(a_origin_phase, clock, reset, rsp_valid && rsp_modulation == 8'd0, rsp_phase_code == 8'sd0, "zero modulation with nonzero phase")

endmodule

/* verif/three_step_phase_wrap_core_test.sv */
// Self-checking testbench for three_step_phase_wrap_core: wrapped phase, modulation and mask.
// Depends on the core RTL only; the expected results come from an exact integer predictor
// with its own Q4.60 angle tables, built at time zero.
module three_step_phase_wrap_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] PI_Q4_60   = 64'd3622009729038561421;
   localparam int          Q_FRAC     = 60;
   localparam int          N_STEPS    = 64;
   localparam logic [8:0]  THR_AT_RESET = 9'd64;
   localparam int          HOLD_OFF_CYCLES = 150;

   typedef struct packed {
      logic [7:0] one;
      logic [7:0] two;
      logic [7:0] three;
   } pixel_type;

   typedef struct packed {
      logic signed [7:0] phase;
      logic [7:0]        modv;
      logic              masked;
   } pixel_result_type;

   typedef enum int {PIX_UNIFORM, PIX_LOW_CONTRAST, PIX_AXIS, PIX_RAILS} pixel_style_type;
   typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [7:0]        req_intensity_one;
   logic [7:0]        req_intensity_two;
   logic [7:0]        req_intensity_three;
   logic              rsp_valid;
   logic              rsp_stall;
   logic signed [7:0] rsp_phase_code;
   logic [7:0]        rsp_modulation;
   logic              rsp_masked;
   logic              csr_write_en;
   logic [8:0]        csr_write_data;

   // predictor state: threshold copy and angle tables
   logic [8:0]       threshold_model;
   logic [63:0]      cos3_sq_tab [N_STEPS];
   logic [63:0]      sin_sq_tab  [N_STEPS];
   pixel_result_type expected_pixels[$];

   // sender burst control
   bit gaps_enabled;
   int burst_left;

   // receiver hold-off handshake between test and stall driver
   bit hold_request;
   bit hold_active;

   int mismatch_count;
   int pixels_sent;
   int results_checked;
   int masked_seen;
   int input_stall_cycles;
   int threshold_writes;

   three_step_phase_wrap_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_intensity_one   (req_intensity_one),
      .req_intensity_two   (req_intensity_two),
      .req_intensity_three (req_intensity_three),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_phase_code      (rsp_phase_code),
      .rsp_modulation      (rsp_modulation),
      .rsp_masked          (rsp_masked),
      .csr_write_en        (csr_write_en),
      .csr_write_data      (csr_write_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // truncated Q4.60 product
   function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'b0, a} * {64'b0, b};
      return p[Q_FRAC+63:Q_FRAC];
   endfunction

   // Taylor series of sine (odd) or cosine, first quadrant, Q4.60
   function automatic logic [63:0] trig_series(input logic [63:0] x, input bit odd);
      logic [63:0] x2, t, pos, neg;
      int          n;
      x2  = q_mul(x, x);
      t   = odd ? x : (64'd1 << Q_FRAC);
      pos = t;
      neg = 64'd0;
      for (n = int'(odd); n <= 30; n += 2) begin
         t = q_mul(t, x2) / 64'((n + 1) * (n + 2));
         if (((n >> 1) & 1) == 0)
            neg = neg + t;
         else
            pos = pos + t;
      end
      return pos - neg;
   endfunction

   // Number of angle steps k*pi/128 (k = 1..63) below atan(sqrt3*a/b), a and b positive
   function automatic int quadrant_steps(input int a, input int b);
      logic [127:0] lhs, rhs;
      int           k;
      int           steps;
      steps = 0;
      for (k = 1; k < N_STEPS; k++) begin
         lhs = 128'(a * a) * 128'(cos3_sq_tab[k]);
         rhs = 128'(b * b) * 128'(sin_sq_tab[k]);
         if (lhs > rhs)
            steps++;
      end
      return steps;
   endfunction

   function automatic pixel_result_type predict_pixel(input pixel_type px);
      pixel_result_type res;
      int               v, u, code, mag, energy, root;
      v = int'(px.one) - int'(px.three);
      u = 2 * int'(px.two) - int'(px.one) - int'(px.three);
      // axes first, then the quadrant search
      if (v == 0) begin
         code = (u < 0) ? -128 : 0;
      end else if (u == 0) begin
         code = (v > 0) ? 64 : -64;
      end else begin
         mag  = quadrant_steps((v < 0) ? -v : v, (u < 0) ? -u : u);
         mag  = (u > 0) ? mag : 127 - mag;
         code = (v > 0) ? mag : -mag;
      end
      energy = 3 * v * v + u * u;
      if (energy >= 65536) begin
         root = 255;
      end else begin
         root = 0;
         while ((root + 1) * (root + 1) <= energy)
            root++;
      end
      res.phase  = code[7:0];
      res.modv   = root[7:0];
      res.masked = (root < int'(threshold_model));
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      pixel_result_type exp_px;
      if (!reset) begin
         if (req_valid && req_stall)
            input_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected result: phase_code %0d modulation %0d masked %0b",
                      rsp_phase_code, rsp_modulation, rsp_masked);
               mismatch_count++;
            end else begin
               exp_px = expected_pixels.pop_front();
               results_checked++;
               if (rsp_masked)
                  masked_seen++;
               if (rsp_phase_code !== exp_px.phase) begin
                  $error("phase_code: expected %0d, actual %0d", exp_px.phase, rsp_phase_code);
                  mismatch_count++;
               end
               if (rsp_modulation !== exp_px.modv) begin
                  $error("modulation: expected %0d, actual %0d", exp_px.modv, rsp_modulation);
                  mismatch_count++;
               end
               if (rsp_masked !== exp_px.masked) begin
                  $error("masked: expected %0b, actual %0b", exp_px.masked, rsp_masked);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver stall driver: random patterns, plus a long hold-off on request
   // ---------------------------------------------------------------------

   initial begin : rsp_stall_driver
      rx_mode_type mode;
      int          mode_left, period, duty, tick, n;
      rsp_stall <= 1'b0;
      mode      = RX_FLOW;
      mode_left = 0;
      period    = 4;
      duty      = 1;
      tick      = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            // long hold-off so the pipeline fills and pushes back on the input
            hold_request = 1'b0;
            hold_active  = 1'b1;
            rsp_stall   <= 1'b1;
            for (n = 0; n < HOLD_OFF_CYCLES; n++)
               @(posedge clock);
            hold_active  = 1'b0;
            rsp_stall   <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 300);
               period    = $urandom_range(2, 9);
               duty      = $urandom_range(1, period - 1);
            end
            mode_left--;
            tick++;
            case (mode)
               RX_FLOW:     rsp_stall <= 1'b0;
               RX_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
               RX_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
               RX_PERIODIC: rsp_stall <= ((tick % period) < duty);
               default:     rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------

   // Offer one pixel, wait for acceptance, record the expected result.
   // Valid stays high afterwards so back-to-back requests need no re-raise.
   task automatic send_pixel(input pixel_type px);
      int gap;
      if (gaps_enabled && burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0)
         burst_left--;
      req_valid           <= 1'b1;
      req_intensity_one   <= px.one;
      req_intensity_two   <= px.two;
      req_intensity_three <= px.three;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      expected_pixels = {expected_pixels, predict_pixel(px)};
      pixels_sent++;
   endtask

   task automatic send_levels(input int i1, input int i2, input int i3);
      pixel_type px;
      px.one   = i1[7:0];
      px.two   = i2[7:0];
      px.three = i3[7:0];
      send_pixel(px);
   endtask

   // Drop valid and wait until every outstanding pixel has come back
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Threshold register write, only with the pipeline empty
   task automatic write_threshold(input logic [8:0] value);
      drain_pipeline();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      threshold_model = value;
      threshold_writes++;
      @(posedge clock);
   endtask

   function automatic int clamp_level(input int x);
      return (x < 0) ? 0 : ((x > 255) ? 255 : x);
   endfunction

   // Random pixel, mixing full-range, low-contrast, on-axis and rail values
   function automatic pixel_type random_pixel();
      pixel_type       px;
      pixel_style_type style;
      int              pick, base, spread, lo, hi;
      pick = $urandom_range(0, 9);
      if (pick < 4)
         style = PIX_UNIFORM;
      else if (pick < 7)
         style = PIX_LOW_CONTRAST;
      else if (pick < 9)
         style = PIX_AXIS;
      else
         style = PIX_RAILS;
      px = pixel_type'($urandom);
      case (style)
         PIX_LOW_CONTRAST: begin
            base     = $urandom_range(0, 255);
            spread   = $urandom_range(0, 24);
            px.one   = 8'(clamp_level(base + int'($urandom_range(0, 2 * spread)) - spread));
            px.two   = 8'(clamp_level(base + int'($urandom_range(0, 2 * spread)) - spread));
            px.three = 8'(clamp_level(base + int'($urandom_range(0, 2 * spread)) - spread));
         end
         PIX_AXIS: begin
            if ($urandom_range(0, 1) == 0) begin
               // first and third equal: phase on the real axis
               px.three = px.one;
            end else begin
               // second is the mean of the other two: phase at plus or minus half pi
               lo       = $urandom_range(0, 255);
               hi       = $urandom_range(0, 127) * 2 + (lo & 1);
               hi       = (hi > 255) ? hi - 2 : hi;
               px.one   = 8'(lo);
               px.three = 8'(hi);
               px.two   = 8'((lo + hi) / 2);
            end
         end
         PIX_RAILS: begin
            px.one   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            px.two   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            px.three = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         default: ;
      endcase
      return px;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Axis cases, saturation, extremes and the mask edge at the reset threshold
   task automatic test_axis_and_extremes();
      send_levels(0, 0, 0);        // no fringe at all
      send_levels(255, 255, 255);
      send_levels(10, 200, 10);    // on the positive real axis
      send_levels(200, 10, 200);   // on the negative real axis, reads as -128
      send_levels(255, 0, 255);    // negative axis, modulation saturates
      send_levels(0, 255, 0);      // positive axis, modulation saturates
      send_levels(200, 100, 0);    // plus half pi
      send_levels(0, 100, 200);    // minus half pi
      send_levels(255, 128, 1);
      send_levels(1, 128, 255);
      send_levels(255, 0, 0);
      send_levels(0, 0, 255);
      send_levels(255, 255, 0);
      send_levels(0, 255, 255);
      send_levels(1, 0, 0);
      send_levels(0, 0, 1);
      send_levels(0, 1, 0);
      send_levels(1, 32, 0);       // modulation 63, just under the reset threshold
      send_levels(0, 32, 0);       // modulation 64, just at it
      send_levels(170, 85, 85);
      send_levels(85, 170, 170);
   endtask

   // Threshold at its extremes and in between, with a short mixed stream each
   task automatic test_threshold_settings();
      logic [8:0] settings [7];
      int         s, n;
      settings = '{9'd0, 9'd1, 9'd255, 9'd256, 9'd511, 9'(THR_AT_RESET), 9'd0};
      settings[6] = 9'($urandom_range(2, 80));
      for (s = 0; s < 7; s++) begin
         write_threshold(settings[s]);
         for (n = 0; n < 26; n++)
            send_pixel(random_pixel());
      end
   endtask

   // Receiver holds off long enough that the input side must stall
   task automatic test_output_hold_off();
      int n;
      drain_pipeline();
      gaps_enabled = 1'b0;
      hold_request = 1'b1;
      while (!hold_active)
         @(posedge clock);
      for (n = 0; n < 80; n++)
         send_pixel(random_pixel());
      gaps_enabled = 1'b1;
   endtask

   // Long random stream in several phases, threshold rewritten between them
   task automatic test_random_frames();
      int f, n;
      for (f = 0; f < 5; f++) begin
         if ($urandom_range(0, 1) == 0)
            write_threshold(9'($urandom_range(0, 256)));
         else
            write_threshold(9'($urandom_range(0, 90)));
         for (n = 0; n < 230; n++)
            send_pixel(random_pixel());
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin : main_sequence
      int k;
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_intensity_one   <= 8'd0;
      req_intensity_two   <= 8'd0;
      req_intensity_three <= 8'd0;
      csr_write_en        <= 1'b0;
      csr_write_data      <= 9'd0;
      threshold_model     = THR_AT_RESET;
      gaps_enabled        = 1'b1;
      burst_left          = 0;
      hold_request        = 1'b0;
      hold_active         = 1'b0;
      mismatch_count      = 0;
      pixels_sent         = 0;
      results_checked     = 0;
      masked_seen         = 0;
      input_stall_cycles  = 0;
      threshold_writes    = 0;

      // angle tables: 3*cos^2 and sin^2 of k*pi/128
      cos3_sq_tab[0] = 64'd0;
      sin_sq_tab[0]  = 64'd0;
      for (k = 1; k < N_STEPS; k++) begin
         cos3_sq_tab[k] = 64'd3 * q_mul(trig_series((PI_Q4_60 >> 7) * 64'(k), 1'b0),
                                        trig_series((PI_Q4_60 >> 7) * 64'(k), 1'b0));
         sin_sq_tab[k]  = q_mul(trig_series((PI_Q4_60 >> 7) * 64'(k), 1'b1),
                                trig_series((PI_Q4_60 >> 7) * 64'(k), 1'b1));
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_axis_and_extremes();
      test_threshold_settings();
      test_output_hold_off();
      test_random_frames();

      // let the tail drain, then wait on for any stray results
      drain_pipeline();
      repeat (40) @(posedge clock);

      $display("Checked %0d of %0d pixels, %0d masked, over %0d threshold settings.",
               results_checked, pixels_sent, masked_seen, threshold_writes + 1);
      $display("Input side was held back for %0d cycles; %0d mismatches.",
               input_stall_cycles, mismatch_count);
      if (mismatch_count == 0 && expected_pixels.size() == 0)
         $display("three_step_phase_wrap_core test passed");
      else
         $display("three_step_phase_wrap_core test failed");
      $finish;
   end

   // Watchdog, far above the slowest legal run
   initial begin : watchdog
      #3000000;
      $display("Timeout with %0d pixels outstanding.", expected_pixels.size());
      $display("three_step_phase_wrap_core test failed");
      $finish;
   end

endmodule
